// ===== rtl/gfr_pkg.sv =====
package gfr_pkg;

    localparam int StoreDepth = 1024;
    localparam int StoreAw    = 10;

    localparam logic [7:0] GlyphFirst = 8'h20;
    localparam logic [7:0] GlyphLast  = 8'h5A;
    localparam logic [7:0] LowerFirst = 8'h61;
    localparam logic [7:0] LowerLast  = 8'h7A;
    localparam logic [2:0] GlyphLastCol = 3'd4;

    typedef enum logic [1:0] {
        FN_CLEAR = 2'd0,
        FN_CHAR  = 2'd1,
        FN_PIXEL = 2'd2,
        FN_READ  = 2'd3
    } t_func;

    // sequencer steps, in microcode address order
    typedef enum logic [3:0] {
        ST_IDLE = 4'd0,
        ST_GCHK = 4'd1,
        ST_RDA  = 4'd2,
        ST_WRA  = 4'd3,
        ST_RDB  = 4'd4,
        ST_WRB  = 4'd5,
        ST_DONE = 4'd6,
        ST_CLR  = 4'd7,
        ST_CLRJ = 4'd8,
        ST_PRD  = 4'd9,
        ST_PWR  = 4'd10,
        ST_RRD  = 4'd11,
        ST_RCAP = 4'd12
    } t_step;

    typedef enum logic [1:0] {
        AS_SWEEP = 2'd0,
        AS_IDX   = 2'd1,
        AS_PAGEA = 2'd2,
        AS_PAGEB = 2'd3
    } t_asel;

    typedef enum logic [2:0] {
        JC_NONE     = 3'd0,
        JC_ALWAYS   = 3'd1,
        JC_DISPATCH = 3'd2,
        JC_BADCODE  = 3'd3,
        JC_COLMORE  = 3'd4,
        JC_SWPMORE  = 3'd5
    } t_jcond;

    typedef struct packed {
        logic   wr;         // framebuffer write this step
        logic   zero;       // write zero instead of merged byte
        t_asel  asel;
        logic   sweep_inc;
        logic   col_inc;
        logic   cap;        // capture read data
        logic   done;
        t_jcond jc;
        t_step  target;
    } t_uword;

    function automatic t_uword ucode(t_step pc);
        t_uword w;
        w = '{wr: 1'b0, zero: 1'b0, asel: AS_PAGEA, sweep_inc: 1'b0, col_inc: 1'b0,
              cap: 1'b0, done: 1'b0, jc: JC_NONE, target: ST_IDLE};
        case (pc)
            ST_IDLE: begin
                w.jc = JC_DISPATCH;
            end
            ST_GCHK: begin
                w.jc     = JC_BADCODE;
                w.target = ST_DONE;
            end
            ST_RDA: begin
                w.asel = AS_PAGEA;
            end
            ST_WRA: begin
                w.asel = AS_PAGEA;
                w.wr   = 1'b1;
            end
            ST_RDB: begin
                w.asel = AS_PAGEB;
            end
            ST_WRB: begin
                w.asel    = AS_PAGEB;
                w.wr      = 1'b1;
                w.col_inc = 1'b1;
                w.jc      = JC_COLMORE;
                w.target  = ST_RDA;
            end
            ST_DONE: begin
                w.done   = 1'b1;
                w.jc     = JC_ALWAYS;
                w.target = ST_IDLE;
            end
            ST_CLR: begin
                w.asel      = AS_SWEEP;
                w.wr        = 1'b1;
                w.zero      = 1'b1;
                w.sweep_inc = 1'b1;
                w.jc        = JC_SWPMORE;
                w.target    = ST_CLR;
            end
            ST_CLRJ: begin
                w.jc     = JC_ALWAYS;
                w.target = ST_DONE;
            end
            ST_PRD: begin
                w.asel = AS_PAGEA;
            end
            ST_PWR: begin
                w.asel   = AS_PAGEA;
                w.wr     = 1'b1;
                w.jc     = JC_ALWAYS;
                w.target = ST_DONE;
            end
            ST_RRD: begin
                w.asel = AS_IDX;
            end
            ST_RCAP: begin
                w.asel   = AS_IDX;
                w.cap    = 1'b1;
                w.jc     = JC_ALWAYS;
                w.target = ST_DONE;
            end
            default: begin
                w.jc     = JC_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic t_step entry(t_func f);
        t_step s;
        case (f)
            FN_CLEAR: s = ST_CLR;
            FN_CHAR:  s = ST_GCHK;
            FN_PIXEL: s = ST_PRD;
            FN_READ:  s = ST_RRD;
            default:  s = ST_IDLE;
        endcase
        return s;
    endfunction

    // 5x7 font, column-major, leftmost column in the top byte; bit 0 is the top row
    function automatic logic [39:0] glyph_row(logic [5:0] idx);
        logic [39:0] g;
        case (idx)
            6'd0:  g = 40'h0000000000; 6'd1:  g = 40'h00005F0000;
            6'd2:  g = 40'h0007000700; 6'd3:  g = 40'h147F147F14;
            6'd4:  g = 40'h242A7F2A12; 6'd5:  g = 40'h2313086462;
            6'd6:  g = 40'h3649552250; 6'd7:  g = 40'h0005030000;
            6'd8:  g = 40'h001C224100; 6'd9:  g = 40'h0041221C00;
            6'd10: g = 40'h082A1C2A08; 6'd11: g = 40'h08083E0808;
            6'd12: g = 40'h0050300000; 6'd13: g = 40'h0808080808;
            6'd14: g = 40'h0060600000; 6'd15: g = 40'h2010080402;
            6'd16: g = 40'h3E5149453E; 6'd17: g = 40'h00427F4000;
            6'd18: g = 40'h4261514946; 6'd19: g = 40'h2141454B31;
            6'd20: g = 40'h1814127F10; 6'd21: g = 40'h2745454539;
            6'd22: g = 40'h3C4A494930; 6'd23: g = 40'h0171090503;
            6'd24: g = 40'h3649494936; 6'd25: g = 40'h064949291E;
            6'd26: g = 40'h0036360000; 6'd27: g = 40'h0056360000;
            6'd28: g = 40'h0008142241; 6'd29: g = 40'h1414141414;
            6'd30: g = 40'h4122140800; 6'd31: g = 40'h0201510906;
            6'd32: g = 40'h324979413E; 6'd33: g = 40'h7E1111117E;
            6'd34: g = 40'h7F49494936; 6'd35: g = 40'h3E41414122;
            6'd36: g = 40'h7F4141221C; 6'd37: g = 40'h7F49494941;
            6'd38: g = 40'h7F09090901; 6'd39: g = 40'h3E4149497A;
            6'd40: g = 40'h7F0808087F; 6'd41: g = 40'h00417F4100;
            6'd42: g = 40'h2040413F01; 6'd43: g = 40'h7F08142241;
            6'd44: g = 40'h7F40404040; 6'd45: g = 40'h7F020C027F;
            6'd46: g = 40'h7F0408107F; 6'd47: g = 40'h3E4141413E;
            6'd48: g = 40'h7F09090906; 6'd49: g = 40'h3E4151215E;
            6'd50: g = 40'h7F09192946; 6'd51: g = 40'h4649494931;
            6'd52: g = 40'h01017F0101; 6'd53: g = 40'h3F4040403F;
            6'd54: g = 40'h1F2040201F; 6'd55: g = 40'h3F4038403F;
            6'd56: g = 40'h6314081463; 6'd57: g = 40'h0708700807;
            6'd58: g = 40'h6151494543;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/gfr_ram.sv =====
module gfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end

endmodule

// ===== rtl/glyph_framebuffer_renderer_unit.sv =====
// Page-organized monochrome framebuffer (1024 bytes, bit 0 = top pixel of a page)
// with a built-in 5x7 font. A transaction is taken when start is high and busy is
// low; exactly one result follows, marked by o_valid for a single cycle, and it
// cannot be held off. Each cycle is one microcode step on the single-port
// framebuffer RAM: a pixel write is one read-modify-write, a byte read is one
// read, a character is five columns times two pages of read-modify-write (a
// glyph code outside the font writes nothing), and clear writes one byte per
// cycle. After reset the block stays busy while it zeroes the framebuffer.
module glyph_framebuffer_renderer_unit
    import gfr_pkg::*;
#(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_func,
    input  logic signed [8:0] i_x_pos,
    input  logic signed [7:0] i_y_pos,
    input  logic [7:0] i_char_code,
    input  logic       i_pixel_on,
    input  logic [9:0] i_byte_index,
    output logic       o_valid,
    output logic [7:0] o_read_data,
    output logic [1:0] o_op_done
);

    t_step  r_pc, n_pc;
    logic   r_boot, n_boot;
    t_uword uw;

    t_func        r_func;
    logic [8:0]   r_x;
    logic [7:0]   r_y;
    logic [7:0]   r_code;
    logic         r_lit;
    logic [9:0]   r_idx;
    logic [9:0]   r_sweep;
    logic [2:0]   r_col;
    logic [7:0]   r_rdata;

    logic         accept;
    logic [7:0]   folded;
    logic         bad_code;
    logic [5:0]   gidx;
    logic [39:0]  gword;
    logic [2:0]   col_sel;
    logic [6:0]   cell_mask;
    logic [6:0]   cell_data;
    logic [14:0]  mask15;
    logic [14:0]  data15;
    logic [9:0]   px;
    logic         px_ok;
    logic [5:0]   page_a;
    logic [5:0]   page_b;
    logic [5:0]   page;
    logic [12:0]  page_base;
    logic [12:0]  pix_addr;
    logic         page_ok;
    logic [7:0]   row_ok;
    logic [7:0]   bmask;
    logic [7:0]   bdata;
    logic [StoreAw-1:0] ram_addr;
    logic         ram_we;
    logic [7:0]   ram_wdata;
    logic [7:0]   ram_q;

    assign uw     = ucode(r_pc);
    assign busy   = (r_pc != ST_IDLE);
    assign accept = start && !busy;

    // glyph lookup with lowercase folding
    always_comb begin
        folded = r_code;
        if (r_code >= LowerFirst && r_code <= LowerLast) begin
            folded = r_code - 8'h20;
        end
        bad_code = (folded < GlyphFirst) || (folded > GlyphLast);
        gidx     = 6'(folded - GlyphFirst);
        gword    = glyph_row(gidx);
        col_sel  = GlyphLastCol - r_col;
    end

    always_comb begin
        if (r_func == FN_PIXEL) begin
            cell_mask = 7'h01;
            cell_data = {6'b0, r_lit};
        end else begin
            cell_mask = 7'h7F;
            cell_data = gword[{col_sel, 3'b000} +: 7];
        end
        mask15 = 15'(cell_mask) << r_y[2:0];
        data15 = 15'(cell_data) << r_y[2:0];
    end

    // pixel column and page address; the cell may straddle two pages
    always_comb begin
        px     = {r_x[8], r_x} + {7'b0, r_col};
        px_ok  = !px[9] && (px < 10'(PANEL_WIDTH));
        page_a = {r_y[7], r_y[7:3]};
        page_b = page_a + 6'd1;
        page   = (uw.asel == AS_PAGEB) ? page_b : page_a;
        page_base = 13'(page[4:0]) * 13'(PANEL_WIDTH);
        pix_addr  = page_base + {3'b0, px};
        page_ok   = !page[5] && px_ok && (pix_addr < 13'(StoreDepth));
        for (int b = 0; b < 8; b++) begin
            row_ok[b] = ({page[4:0], 3'(b)} < 8'(PANEL_HEIGHT));
        end
        if (uw.asel == AS_PAGEB) begin
            bmask = {1'b0, mask15[14:8]} & row_ok;
            bdata = {1'b0, data15[14:8]};
        end else begin
            bmask = mask15[7:0] & row_ok;
            bdata = data15[7:0];
        end
    end

    always_comb begin
        case (uw.asel)
            AS_SWEEP: ram_addr = r_sweep;
            AS_IDX:   ram_addr = r_idx;
            default:  ram_addr = pix_addr[StoreAw-1:0];
        endcase
        if (uw.zero) begin
            ram_wdata = '0;
            ram_we    = uw.wr;
        end else begin
            ram_wdata = (ram_q & ~bmask) | (bdata & bmask);
            ram_we    = uw.wr && page_ok;
        end
    end

    gfr_ram #(
        .WIDTH (8),
        .DEPTH (StoreDepth)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= ST_CLR;
            r_boot <= 1'b1;
        end else begin
            r_pc   <= n_pc;
            r_boot <= n_boot;
        end
    end

    always_comb begin
        n_pc   = t_step'(r_pc + 4'd1);
        n_boot = r_boot;
        case (uw.jc)
            JC_NONE:     n_pc = t_step'(r_pc + 4'd1);
            JC_ALWAYS:   n_pc = uw.target;
            JC_DISPATCH: n_pc = start ? entry(t_func'(i_func)) : ST_IDLE;
            JC_BADCODE:  if (bad_code) n_pc = uw.target;
            JC_COLMORE:  if (r_col != GlyphLastCol) n_pc = uw.target;
            JC_SWPMORE:  if (r_sweep != '1) n_pc = uw.target;
            default:     n_pc = ST_IDLE;
        endcase
        if (uw.done) begin
            n_boot = 1'b0;
        end
        o_valid = uw.done && !r_boot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
            r_col   <= '0;
        end else begin
            if (accept) begin
                r_sweep <= '0;
                r_col   <= '0;
            end else begin
                if (uw.sweep_inc) r_sweep <= r_sweep + 10'd1;
                if (uw.col_inc)   r_col   <= r_col + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= t_func'(i_func);
            r_x     <= i_x_pos;
            r_y     <= i_y_pos;
            r_code  <= i_char_code;
            r_lit   <= i_pixel_on;
            r_idx   <= i_byte_index;
            r_rdata <= '0;
        end else if (uw.cap) begin
            r_rdata <= ram_q;
        end
    end

    assign o_read_data = r_rdata;
    assign o_op_done   = r_func;

    a_valid_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("result strobe not followed by idle");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start the sequencer");

    a_read_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_op_done != FN_READ) |-> (o_read_data == 8'h00))
        else $error("nonzero read data on a non-read result");

    a_write_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> busy)
        else $error("framebuffer write while idle");

endmodule
